// ===== src/apcs_pkg.sv =====
package apcs_pkg;

	localparam int MAX_ACTORS_DEF = 8;
	localparam int COORD_BITS_DEF = 16;
	localparam int IDX_BITS = 3;

	typedef struct packed {
		logic signed [15:0] rect_left;
		logic signed [15:0] rect_right;
		logic signed [15:0] rect_top;
		logic signed [15:0] rect_bottom;
		logic signed [15:0] circle_x;
		logic signed [15:0] circle_y;
		logic [14:0] circle_radius;
		logic last_actor;
	} actor_req_t;

	typedef struct packed {
		logic pair_valid;
		logic [2:0] first_index;
		logic [2:0] second_index;
		logic first_shape;
		logic second_shape;
		logic overflow;
		logic last_result;
	} scan_res_t;

	// Kinds of hit that a pair test can report.
	typedef enum logic [1:0] {
		HIT_NONE = 2'd0,
		HIT_RR = 2'd1,
		HIT_CR = 2'd2,
		HIT_CC = 2'd3
	} hit_t;

endpackage

// ===== src/apcs_cell.sv =====
// One storage cell of the actor chain. During load, records shift in from
// the left neighbor; during the scan the chain rotates one place per cycle while shift is high.
module apcs_cell (
	input logic clk,
	input logic shift,
	input apcs_pkg::actor_req_t din,
	output apcs_pkg::actor_req_t dout
);

	apcs_pkg::actor_req_t rec_q;

	// Payload register, no reset needed.
	always_ff @(posedge clk) begin
		if (shift) begin
			rec_q <= din;
		end
	end

	assign dout = rec_q;

endmodule

// ===== src/apcs_test.sv =====
// Two-stage pair test: stage one forms the distance magnitudes and the radius sum, stage two
// squares and compares. Every product is at most 16 by 16 bits.
module apcs_test (
	input logic clk,
	input logic en,
	input apcs_pkg::actor_req_t a,
	input apcs_pkg::actor_req_t b,
	output apcs_pkg::hit_t hit
);

	logic rr_c;
	logic [15:0] cr_dx_c, cr_dy_c, cc_dx_c, cc_dy_c;
	logic [15:0] sum_c;
	logic rr_s1;
	logic [15:0] cr_dx_s1, cr_dy_s1, cc_dx_s1, cc_dy_s1;
	logic [14:0] ra_s1;
	logic [15:0] sum_s1;
	logic [31:0] cr_px, cr_py, cc_px, cc_py, cc_r;
	logic [29:0] cr_r;
	logic [32:0] cr_d, cc_d;

	// Rectangle overlap, and distances from circle a to the nearest point of rectangle b
	// and to the center of circle b, all as magnitudes.
	always_comb begin
		rr_c = !(a.rect_left > b.rect_right) && !(a.rect_top > b.rect_bottom) &&
			!(a.rect_right < b.rect_left) && !(a.rect_bottom < b.rect_top);
		if (a.circle_x > b.rect_right) cr_dx_c = 16'(17'(a.circle_x) - 17'(b.rect_right));
		else if (a.circle_x < b.rect_left) cr_dx_c = 16'(17'(b.rect_left) - 17'(a.circle_x));
		else cr_dx_c = '0;
		if (a.circle_y < b.rect_top) cr_dy_c = 16'(17'(b.rect_top) - 17'(a.circle_y));
		else if (a.circle_y > b.rect_bottom) cr_dy_c = 16'(17'(a.circle_y) - 17'(b.rect_bottom));
		else cr_dy_c = '0;
		if (a.circle_x > b.circle_x) cc_dx_c = 16'(17'(a.circle_x) - 17'(b.circle_x));
		else cc_dx_c = 16'(17'(b.circle_x) - 17'(a.circle_x));
		if (a.circle_y > b.circle_y) cc_dy_c = 16'(17'(a.circle_y) - 17'(b.circle_y));
		else cc_dy_c = 16'(17'(b.circle_y) - 17'(a.circle_y));
		sum_c = 16'(a.circle_radius) + 16'(b.circle_radius);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rr_s1 <= rr_c;
			cr_dx_s1 <= cr_dx_c;
			cr_dy_s1 <= cr_dy_c;
			cc_dx_s1 <= cc_dx_c;
			cc_dy_s1 <= cc_dy_c;
			ra_s1 <= a.circle_radius;
			sum_s1 <= sum_c;
		end
	end

	// Exact squared distances against squared radii.
	always_comb begin
		cr_px = 32'(cr_dx_s1) * 32'(cr_dx_s1);
		cr_py = 32'(cr_dy_s1) * 32'(cr_dy_s1);
		cc_px = 32'(cc_dx_s1) * 32'(cc_dx_s1);
		cc_py = 32'(cc_dy_s1) * 32'(cc_dy_s1);
		cr_d = 33'(cr_px) + 33'(cr_py);
		cc_d = 33'(cc_px) + 33'(cc_py);
		cr_r = 30'(ra_s1) * 30'(ra_s1);
		cc_r = 32'(sum_s1) * 32'(sum_s1);
		if (rr_s1) hit = apcs_pkg::HIT_RR;
		else if (cr_d <= 33'(cr_r)) hit = apcs_pkg::HIT_CR;
		else if (cc_d <= 33'(cc_r)) hit = apcs_pkg::HIT_CC;
		else hit = apcs_pkg::HIT_NONE;
	end

endmodule

// ===== src/all_pairs_collision_scan.sv =====
// Load: one actor request per cycle while loading; no result until the last one.
// Scan: with n >= 2 stored actors the chain makes n*(n-1) rotation steps plus one flush step,
// and the done result is registered after the flush; with n < 2 no scan runs.
// A stalled result freezes the whole scan.
// Loading reopens as soon as the done result is registered.
// Reset (arst_n low) clears the count, drop flag, sequencer and output valid.
module all_pairs_collision_scan #(
	parameter int MAX_ACTORS = apcs_pkg::MAX_ACTORS_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input apcs_pkg::actor_req_t in_data,
	output logic out_valid,
	input logic out_ready,
	output apcs_pkg::scan_res_t out_data
);

	localparam int CW = $clog2(MAX_ACTORS + 1);
	localparam int AW = $clog2(MAX_ACTORS);
	localparam int IW = apcs_pkg::IDX_BITS;

	typedef enum logic [2:0] {
		ST_LOAD = 3'b001,
		ST_SCAN = 3'b010,
		ST_DONE = 3'b100
	} state_t;

	state_t state_q;
	logic [CW-1:0] count_q, i_q, p_q;
	logic dropped_q, flush_q;
	logic pv_s1;
	logic [IW-1:0] pi_s1, pj_s1;
	apcs_pkg::actor_req_t chain [MAX_ACTORS];
	apcs_pkg::actor_req_t cell_in [MAX_ACTORS];
	apcs_pkg::actor_req_t head_q, feed;
	apcs_pkg::scan_res_t pair_res, done_res;
	apcs_pkg::hit_t hit;
	logic load_fire, full, shift, step, out_free, pair_hit, done_emit;

	assign in_ready = (state_q == ST_LOAD);
	assign load_fire = in_valid && in_ready;
	assign full = (count_q == CW'(MAX_ACTORS));
	assign out_free = !out_valid || out_ready;
	// The chain rotates and the test pipe moves only while the result slot can take a hit.
	assign step = (state_q == ST_SCAN) && out_free;
	assign shift = (load_fire && !full) || step;
	// New records enter cell 0. While scanning, the last occupied cell feeds back; after
	// r rotations it holds actor r mod n, which is the actor that p_q names.
	assign feed = (state_q == ST_LOAD) ? in_data : chain[AW'(count_q - CW'(1))];

	// Cell chain: entry k holds the actor loaded k places ago.
	genvar g;
	generate
		for (g = 0; g < MAX_ACTORS; g++) begin : g_cell
			if (g == 0) begin : g_first
				assign cell_in[g] = feed;
			end else begin : g_next
				assign cell_in[g] = chain[g-1];
			end
			apcs_cell u_cell (
				.clk(clk),
				.shift(shift),
				.din(cell_in[g]),
				.dout(chain[g])
			);
		end
	endgenerate

	// Head register holds actor i while the later actors pass by on the feed.
	apcs_test u_test (.clk(clk), .en(step), .a(head_q), .b(feed), .hit(hit));

	// Sequencer: for each first actor i, p sweeps the feed over all n actors; actor i is
	// captured as head at p == i and tested against every later p. One flush step drains
	// the test pipe after the last pair.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
			count_q <= '0;
			dropped_q <= 1'b0;
			flush_q <= 1'b0;
			i_q <= '0;
			p_q <= '0;
			pv_s1 <= 1'b0;
		end else begin
			unique case (state_q)
				ST_LOAD: begin
					if (load_fire) begin
						if (!full) count_q <= count_q + CW'(1);
						else dropped_q <= 1'b1;
						if (in_data.last_actor) begin
							i_q <= '0;
							p_q <= '0;
							flush_q <= 1'b0;
							pv_s1 <= 1'b0;
							// With at most one stored actor there are no pairs.
							if (count_q == '0) state_q <= ST_DONE;
							else state_q <= ST_SCAN;
						end
					end
				end
				ST_SCAN: begin
					if (out_free) begin
						pv_s1 <= (p_q > i_q) && !flush_q;
						if (flush_q) begin
							flush_q <= 1'b0;
							state_q <= ST_DONE;
						end else if (p_q == count_q - CW'(1)) begin
							if (i_q == count_q - CW'(2)) begin
								flush_q <= 1'b1;
							end else begin
								p_q <= '0;
								i_q <= i_q + CW'(1);
							end
						end else begin
							p_q <= p_q + CW'(1);
						end
					end
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_LOAD;
						count_q <= '0;
						dropped_q <= 1'b0;
					end
				end
				default: state_q <= ST_LOAD;
			endcase
		end
	end

	// Pair indices travel beside the test pipe.
	always_ff @(posedge clk) begin
		if (step) begin
			pi_s1 <= IW'(i_q);
			pj_s1 <= IW'(p_q);
		end
	end

	// Head register: captured when the feed presents actor i.
	always_ff @(posedge clk) begin
		if (step && (p_q == i_q)) head_q <= feed;
	end

	// Result contents for a pair hit and for the done marker.
	always_comb begin
		pair_res = '0;
		pair_res.pair_valid = 1'b1;
		pair_res.first_index = pi_s1;
		pair_res.second_index = pj_s1;
		pair_res.first_shape = (hit != apcs_pkg::HIT_RR);
		pair_res.second_shape = (hit == apcs_pkg::HIT_CC);
		done_res = '0;
		done_res.overflow = dropped_q;
		done_res.last_result = 1'b1;
	end

	assign pair_hit = step && pv_s1 && (hit != apcs_pkg::HIT_NONE);
	assign done_emit = (state_q == ST_DONE) && out_free;

	// Result register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (pair_hit || done_emit) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	// Result register payload.
	always_ff @(posedge clk) begin
		if (pair_hit) out_data <= pair_res;
		else if (done_emit) out_data <= done_res;
	end

endmodule

// ===== src/apcs_checker.sv =====
// Port-level checks for the collision scanner.
module apcs_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input apcs_pkg::scan_res_t out_data
);

	// A stalled result holds.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result changed while stalled");

	// Done marker and pair flag exclude each other.
	a_kind: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_data.pair_valid != out_data.last_result))
		else $error("bad result kind");

	// No load while a pair result is pending.
	a_noload: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.pair_valid |-> !in_ready)
		else $error("load open during scan");

	// A waiting request stays offered.
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_ready |=> in_valid)
		else $error("request withdrawn before acceptance");

endmodule

bind all_pairs_collision_scan apcs_checker u_apcs_checker (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
	.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
);

// ===== tb/sv/tb_all_pairs_collision_scan.sv =====
module tb_all_pairs_collision_scan;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int ACTOR_CAP = apcs_pkg::MAX_ACTORS_DEF;
	localparam int CYCLE_LIMIT = 1500000;
	localparam int REQ_BITS = $bits(apcs_pkg::actor_req_t);

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	apcs_pkg::actor_req_t in_data = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	apcs_pkg::scan_res_t out_data;

	// Predictor state: stored actors, count and drop flag of the current batch.
	apcs_pkg::actor_req_t actor_mem[ACTOR_CAP];
	int loaded_count = 0;
	bit drop_seen = 1'b0;
	apcs_pkg::scan_res_t pending_hits[$];
	int error_count = 0;
	int cycle_count = 0;
	bit sink_stalls = 1'b1;
	bit source_gaps = 1'b1;

	all_pairs_collision_scan DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data)
	);

	always #5 clk = ~clk;

	// Watchdog on total run length.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// Rectangle against rectangle, touching edges count.
	function automatic bit rects_touch(apcs_pkg::actor_req_t a, apcs_pkg::actor_req_t b);
		return !(a.rect_left > b.rect_right || a.rect_top > b.rect_bottom ||
			a.rect_right < b.rect_left || a.rect_bottom < b.rect_top);
	endfunction

	// Circle of a against rectangle of b via the clamped nearest point.
	function automatic bit circle_hits_rect(apcs_pkg::actor_req_t a, apcs_pkg::actor_req_t b);
		longint nx, ny, dx, dy, rad;
		if (a.circle_x > b.rect_right) nx = b.rect_right;
		else if (a.circle_x < b.rect_left) nx = b.rect_left;
		else nx = a.circle_x;
		if (a.circle_y < b.rect_top) ny = b.rect_top;
		else if (a.circle_y > b.rect_bottom) ny = b.rect_bottom;
		else ny = a.circle_y;
		dx = longint'(a.circle_x) - nx;
		dy = longint'(a.circle_y) - ny;
		rad = longint'({1'b0, a.circle_radius});
		return dx * dx + dy * dy <= rad * rad;
	endfunction

	function automatic bit circles_touch(apcs_pkg::actor_req_t a, apcs_pkg::actor_req_t b);
		longint dx, dy, s;
		dx = longint'(a.circle_x) - longint'(b.circle_x);
		dy = longint'(a.circle_y) - longint'(b.circle_y);
		s = longint'({1'b0, a.circle_radius}) + longint'({1'b0, b.circle_radius});
		return dx * dx + dy * dy <= s * s;
	endfunction

	// Store one accepted request and, on the last one, queue the scan results.
	task automatic predict_scan(apcs_pkg::actor_req_t req);
		apcs_pkg::scan_res_t res;
		if (loaded_count < ACTOR_CAP) begin
			actor_mem[loaded_count] = req;
			loaded_count++;
		end else begin
			drop_seen = 1'b1;
		end
		if (req.last_actor) begin
			for (int i = 0; i < loaded_count; i++) begin
				for (int j = i + 1; j < loaded_count; j++) begin
					res = '0;
					res.pair_valid = 1'b1;
					res.first_index = i[2:0];
					res.second_index = j[2:0];
					if (rects_touch(actor_mem[i], actor_mem[j])) begin
						pending_hits.push_back(res);
					end else if (circle_hits_rect(actor_mem[i], actor_mem[j])) begin
						res.first_shape = 1'b1;
						pending_hits.push_back(res);
					end else if (circles_touch(actor_mem[i], actor_mem[j])) begin
						res.first_shape = 1'b1;
						res.second_shape = 1'b1;
						pending_hits.push_back(res);
					end
				end
			end
			res = '0;
			res.overflow = drop_seen;
			res.last_result = 1'b1;
			pending_hits.push_back(res);
			loaded_count = 0;
			drop_seen = 1'b0;
		end
	endtask

	// Result checker with random output stalls.
	initial begin
		apcs_pkg::scan_res_t want;
		int stall;
		stall = 0;
		forever begin
			@(posedge clk);
			if (arst_n && out_valid && out_ready) begin
				if (pending_hits.size() == 0) begin
					$display("%0t: expected no result actual %p", $time, out_data);
					error_count++;
				end else begin
					want = pending_hits.pop_front();
					if (out_data !== want) begin
						$display("%0t: expected %p actual %p", $time, want, out_data);
						error_count++;
					end
				end
			end
			if (stall > 0) begin
				stall--;
				out_ready <= 1'b0;
			end else if (sink_stalls && $urandom_range(0, 5) == 0) begin
				stall = $urandom_range(1, 8) - 1;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// Send one request, with an optional random gap before it. Valid stays high after
	// acceptance until the next request, a gap or a drain replaces it.
	task automatic send_actor(apcs_pkg::actor_req_t req);
		if (source_gaps && $urandom_range(0, 5) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= req;
		do @(posedge clk); while (!in_ready);
		predict_scan(req);
	endtask

	function automatic apcs_pkg::actor_req_t random_actor(int spread);
		apcs_pkg::actor_req_t a;
		logic signed [15:0] cx, cy;
		if (spread == 0) begin
			a = REQ_BITS'({$urandom, $urandom, $urandom, $urandom});
		end else begin
			cx = 16'($signed($urandom_range(0, 2 * spread)) - spread);
			cy = 16'($signed($urandom_range(0, 2 * spread)) - spread);
			a.rect_left = cx - 16'($urandom_range(0, spread / 4));
			a.rect_right = cx + 16'($urandom_range(0, spread / 4));
			a.rect_top = cy - 16'($urandom_range(0, spread / 4));
			a.rect_bottom = cy + 16'($urandom_range(0, spread / 4));
			a.circle_x = cx + 16'($urandom_range(0, spread / 2));
			a.circle_y = cy - 16'($urandom_range(0, spread / 2));
			a.circle_radius = 15'($urandom_range(0, spread / 3));
		end
		a.last_actor = 1'b0;
		return a;
	endfunction

	task automatic send_batch(int n, int spread);
		apcs_pkg::actor_req_t a;
		for (int k = 0; k < n; k++) begin
			a = random_actor(spread);
			a.last_actor = (k == n - 1);
			send_actor(a);
		end
	endtask

	// Withdraw the input and wait until every expected result has come.
	task automatic wait_drained();
		in_valid <= 1'b0;
		while (pending_hits.size() != 0) @(posedge clk);
	endtask

	// Lone actor, extreme coordinates, touching edges, inverted boxes and a full store.
	task automatic test_directed();
		apcs_pkg::actor_req_t a;
		a = '0;
		a.last_actor = 1'b1;
		send_actor(a);
		a = '{16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh7fff, 16'sh8000,
			15'h7fff, 1'b0};
		send_actor(a);
		a = '{16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000, 16'sh8000, 16'sh7fff,
			15'h7fff, 1'b0};
		send_actor(a);
		// Rectangles touching exactly at one corner.
		a = '{16'sd0, 16'sd16, 16'sd0, 16'sd16, 16'sd1000, 16'sd1000, 15'd0, 1'b0};
		send_actor(a);
		a = '{16'sd16, 16'sd32, 16'sd16, 16'sd32, -16'sd1000, 16'sd1000, 15'd0, 1'b0};
		send_actor(a);
		// Circle just touching a corner of its own rectangle.
		a = '{16'sd300, 16'sd340, 16'sd400, 16'sd440, 16'sd297, 16'sd396, 15'd5, 1'b0};
		send_actor(a);
		a = '{16'sd500, 16'sd600, 16'sd500, 16'sd600, 16'sd500, 16'sd500, 15'd0, 1'b0};
		send_actor(a);
		// Circles touching exactly, rectangles apart.
		a = '{-16'sd9000, -16'sd8990, 16'sd0, 16'sd1, -16'sd2000, 16'sd0, 15'd3, 1'b0};
		send_actor(a);
		a = '{16'sd9000, 16'sd9010, 16'sd0, 16'sd1, -16'sd1995, 16'sd0, 15'd2, 1'b1};
		send_actor(a);
		wait_drained();
		// Store full: extras dropped, including a dropped last request.
		for (int k = 0; k < ACTOR_CAP + 2; k++) begin
			a = random_actor(0);
			a.last_actor = (k == ACTOR_CAP + 1);
			send_actor(a);
		end
		for (int k = 0; k < ACTOR_CAP; k++) begin
			a = random_actor(0);
			a.last_actor = (k == ACTOR_CAP - 1);
			send_actor(a);
		end
	endtask

	task automatic test_random_batches();
		int n;
		for (int b = 0; b < 78; b++) begin
			n = $urandom_range(0, 9) == 0 ? $urandom_range(9, 11) : $urandom_range(1, 8);
			case ($urandom_range(0, 3))
				0: send_batch(n, 0);
				1: send_batch(n, 200);
				2: send_batch(n, 2000);
				default: send_batch(n, 30000);
			endcase
			if (b == 30) wait_drained();
		end
	endtask

	task automatic test_full_rate();
		source_gaps = 1'b0;
		sink_stalls = 1'b0;
		for (int b = 0; b < 6; b++) send_batch(8, 400);
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random_batches();
		test_full_rate();
		wait_drained();
		repeat (200) @(posedge clk);
		if (error_count == 0 && pending_hits.size() == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end
endmodule
